// File: rtl/core/wsd_pkg.sv
`default_nettype none

package wsd_pkg;

    localparam logic [3:0] OPCODE_CLOSE = 4'h8;

    // result queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  payload_byte;
        logic        final_fragment;
        logic [3:0]  frame_opcode;
        logic        was_masked;
        logic [63:0] frame_length;
        logic [15:0] close_status;
        logic        status_present;
        logic        frame_done;
    } wsd_result_t;

    // up to two results per input byte; a lone result always sits in the first slot
    typedef struct packed {
        logic        first_valid;
        logic        second_valid;
        wsd_result_t first;
        wsd_result_t second;
    } wsd_push_t;

endpackage

`default_nettype wire

// File: rtl/core/wsd_parser.sv
`default_nettype none

module wsd_parser
    import wsd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] data_byte,
    output wsd_push_t       push
);

    localparam logic [2:0] PH_HDR = 3'd0;
    localparam logic [2:0] PH_LEN = 3'd1;
    localparam logic [2:0] PH_EXT = 3'd2;
    localparam logic [2:0] PH_KEY = 3'd3;
    localparam logic [2:0] PH_PAY = 3'd4;

    logic [2:0]  phase_reg,   phase_next;
    logic [3:0]  hdr_cnt_reg, hdr_cnt_next;
    logic        fin_reg,     fin_next;
    logic [3:0]  opcode_reg,  opcode_next;
    logic        mask_reg,    mask_next;
    logic [63:0] length_reg,  length_next;
    logic [31:0] key_reg,     key_next;
    logic [63:0] rem_reg,     rem_next;
    logic [1:0]  pos_reg,     pos_next;
    logic        head_reg,    head_next;
    logic [15:0] status_reg,  status_next;

    logic        after_len;
    logic        hdr_done;
    logic        emit_pay;
    logic        emit_sum;
    logic [7:0]  key_byte;
    logic [7:0]  plain;
    logic        is_close;
    wsd_result_t pay_res;
    wsd_result_t sum_res;

    always_comb
    begin
        unique case (pos_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
        plain = mask_reg ? (data_byte ^ key_byte) : data_byte;
    end

    always_comb
    begin
        phase_next   = phase_reg;
        hdr_cnt_next = hdr_cnt_reg;
        fin_next     = fin_reg;
        opcode_next  = opcode_reg;
        mask_next    = mask_reg;
        length_next  = length_reg;
        key_next     = key_reg;
        rem_next     = rem_reg;
        pos_next     = pos_reg;
        head_next    = head_reg;
        status_next  = status_reg;
        after_len    = 1'b0;
        hdr_done     = 1'b0;
        emit_pay     = 1'b0;
        emit_sum     = 1'b0;

        if (accept)
        begin
            unique case (phase_reg)
                PH_LEN:
                begin
                    mask_next   = data_byte[7];
                    length_next = '0;
                    if (data_byte[6:0] == 7'd126)
                    begin
                        hdr_cnt_next = 4'd2;
                        phase_next   = PH_EXT;
                    end
                    else if (data_byte[6:0] == 7'd127)
                    begin
                        hdr_cnt_next = 4'd8;
                        phase_next   = PH_EXT;
                    end
                    else
                    begin
                        length_next = {57'd0, data_byte[6:0]};
                        after_len   = 1'b1;
                    end
                end
                PH_EXT:
                begin
                    length_next  = {length_reg[55:0], data_byte};
                    hdr_cnt_next = hdr_cnt_reg - 4'd1;
                    after_len    = (hdr_cnt_next == 4'd0);
                end
                PH_KEY:
                begin
                    key_next     = {key_reg[23:0], data_byte};
                    hdr_cnt_next = hdr_cnt_reg - 4'd1;
                    hdr_done     = (hdr_cnt_next == 4'd0);
                end
                PH_PAY:
                begin
                    if ((opcode_reg == OPCODE_CLOSE) && head_reg)
                    begin
                        // first two close bytes form the status code
                        if (pos_reg == 2'd0)
                        begin
                            status_next = {plain, 8'd0};
                        end
                        else
                        begin
                            status_next = {status_reg[15:8], plain};
                            head_next   = 1'b0;
                        end
                    end
                    else
                    begin
                        emit_pay = 1'b1;
                    end
                    pos_next = pos_reg + 2'd1;
                    rem_next = rem_reg - 64'd1;
                    if (rem_reg == 64'd1)
                    begin
                        emit_sum   = 1'b1;
                        phase_next = PH_HDR;
                    end
                end
                default:
                begin
                    // first header byte; unused phase codes land here too
                    fin_next     = data_byte[7];
                    opcode_next  = data_byte[3:0];
                    mask_next    = 1'b0;
                    length_next  = '0;
                    key_next     = '0;
                    pos_next     = '0;
                    head_next    = 1'b0;
                    status_next  = '0;
                    hdr_cnt_next = '0;
                    phase_next   = PH_LEN;
                end
            endcase

            if (after_len)
            begin
                if (mask_next)
                begin
                    hdr_cnt_next = 4'd4;
                    key_next     = '0;
                    phase_next   = PH_KEY;
                end
                else
                begin
                    hdr_done = 1'b1;
                end
            end

            if (hdr_done)
            begin
                if (length_next == 64'd0)
                begin
                    emit_sum   = 1'b1;
                    phase_next = PH_HDR;
                end
                else
                begin
                    rem_next   = length_next;
                    pos_next   = '0;
                    head_next  = 1'b1;
                    phase_next = PH_PAY;
                end
            end
        end
    end

    always_comb
    begin
        is_close = (opcode_next == OPCODE_CLOSE);

        pay_res.result_kind    = 1'b0;
        pay_res.payload_byte   = plain;
        pay_res.final_fragment = fin_next;
        pay_res.frame_opcode   = opcode_next;
        pay_res.was_masked     = mask_next;
        pay_res.frame_length   = length_next;
        pay_res.close_status   = '0;
        pay_res.status_present = 1'b0;
        pay_res.frame_done     = 1'b0;

        sum_res.result_kind    = 1'b1;
        sum_res.payload_byte   = '0;
        sum_res.final_fragment = fin_next;
        sum_res.frame_opcode   = opcode_next;
        sum_res.was_masked     = mask_next;
        sum_res.frame_length   = length_next;
        sum_res.close_status   = is_close ? status_next : 16'd0;
        sum_res.status_present = is_close && (length_next != 64'd0);
        sum_res.frame_done     = 1'b1;

        push.first_valid  = emit_pay || emit_sum;
        push.second_valid = emit_pay && emit_sum;
        push.first        = emit_pay ? pay_res : sum_res;
        push.second       = sum_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HDR;
            hdr_cnt_reg <= '0;
            fin_reg     <= 1'b0;
            opcode_reg  <= '0;
            mask_reg    <= 1'b0;
            length_reg  <= '0;
            key_reg     <= '0;
            rem_reg     <= '0;
            pos_reg     <= '0;
            head_reg    <= 1'b0;
            status_reg  <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            hdr_cnt_reg <= hdr_cnt_next;
            fin_reg     <= fin_next;
            opcode_reg  <= opcode_next;
            mask_reg    <= mask_next;
            length_reg  <= length_next;
            key_reg     <= key_next;
            rem_reg     <= rem_next;
            pos_reg     <= pos_next;
            head_reg    <= head_next;
            status_reg  <= status_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/wsd_result_queue.sv
`default_nettype none

module wsd_result_queue
    import wsd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire wsd_push_t push,
    input  wire logic      pop,
    output wsd_result_t    head,
    output logic           not_empty,
    output logic           no_room
);

    wsd_result_t         mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg,  count_next;
    logic [1:0]          push_n;

    always_comb
    begin
        push_n      = {1'b0, push.first_valid} + {1'b0, push.second_valid};
        wr_ptr_next = wr_ptr_reg + QUEUE_AW'(push_n);
        rd_ptr_next = rd_ptr_reg + QUEUE_AW'(pop);
        count_next  = count_reg + QUEUE_CW'(push_n) - QUEUE_CW'(pop);
        head        = mem[rd_ptr_reg];
        not_empty   = (count_reg != '0);
        // need room for two results before taking another byte
        no_room     = (count_reg > QUEUE_CW'(QUEUE_DEPTH - 2));
    end

    always_ff @(posedge clk)
    begin
        if (push.first_valid)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.second_valid)
        begin
            mem[wr_ptr_reg + QUEUE_AW'(1)] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/websocket_frame_deframer.sv
`default_nettype none
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall   data_byte
// out       output     out_valid / out_stall result_kind .. frame_done
//
// One byte is taken per cycle while in_stall is low; its results land in the
// queue at the edge that takes the byte and may leave at the next edge. The
// last payload byte yields two results (one if it is close status); the
// four-entry queue drains one per cycle while out_stall is low, so in_stall
// rises only when under two slots are free (stalled output, frame-end bursts).
// rst_n is asynchronous: parser returns to expecting a first header byte and
// the queue empties.

module websocket_frame_deframer
    import wsd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             result_kind,
    output logic [7:0]       payload_byte,
    output logic             final_fragment,
    output logic [3:0]       frame_opcode,
    output logic             was_masked,
    output logic [63:0]      frame_length,
    output logic [15:0]      close_status,
    output logic             status_present,
    output logic             frame_done
);

    wsd_push_t   push;
    wsd_result_t head;
    logic        in_xfer;
    logic        out_xfer;
    logic        no_room;

    // transfers on both channels
    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid && !out_stall;
    assign in_stall = no_room;

    // header parse, unmasking and close status capture
    wsd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_xfer),
        .data_byte (data_byte),
        .push      (push)
    );

    // result buffer; decouples the output stall from byte intake
    wsd_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (out_xfer),
        .head      (head),
        .not_empty (out_valid),
        .no_room   (no_room)
    );

    assign result_kind    = head.result_kind;
    assign payload_byte   = head.payload_byte;
    assign final_fragment = head.final_fragment;
    assign frame_opcode   = head.frame_opcode;
    assign was_masked     = head.was_masked;
    assign frame_length   = head.frame_length;
    assign close_status   = head.close_status;
    assign status_present = head.status_present;
    assign frame_done     = head.frame_done;

endmodule

`default_nettype wire

// File: test/websocket_frame_deframer_tb.sv
`default_nettype none

module websocket_frame_deframer_tb;

    import wsd_pkg::*;

    // Frame opcodes used to build stimulus (close comes from the package).
    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    // 7-bit length codes that announce an extended length.
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam int QUIET_LIMIT = 1000; // cycles with no transfer on either side
    localparam int DRAIN_SLACK = 8;    // extra cycles once the queue is empty

    // Decoder position within a frame.
    typedef enum logic [2:0] {
        EXP_HEADER,
        EXP_LENGTH,
        EXP_EXT_LEN,
        EXP_MASK_KEY,
        EXP_PAYLOAD
    } frame_phase_t;

    // How the payload length is written in the header.
    typedef enum logic [1:0] {
        FORM_SHORT,
        FORM_EXT16,
        FORM_EXT64
    } len_form_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_stall;
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic        final_fragment;
    logic [3:0]  frame_opcode;
    logic        was_masked;
    logic [63:0] frame_length;
    logic [15:0] close_status;
    logic        status_present;
    logic        frame_done;

    websocket_frame_deframer DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_kind    (result_kind),
        .payload_byte   (payload_byte),
        .final_fragment (final_fragment),
        .frame_opcode   (frame_opcode),
        .was_masked     (was_masked),
        .frame_length   (frame_length),
        .close_status   (close_status),
        .status_present (status_present),
        .frame_done     (frame_done)
    );

    always #6 clk = ~clk;

    // Shaping of the two channels; changed per phase by the test tasks.
    int send_idle_pct;
    int stall_pct;

    int bytes_sent;
    int error_count;
    int quiet_cycles;

    // Results the decoder expects, oldest first.
    wsd_result_t decoded_queue[$];

    // In-bench decoder state.
    frame_phase_t dec_phase;
    logic [3:0]   hdr_left;    // extended-length or key bytes still to come
    logic         cur_fin;
    logic [3:0]   cur_opcode;
    logic         cur_masked;
    logic [63:0]  cur_length;
    logic [31:0]  cur_key;
    logic [63:0]  pay_pos;
    logic [15:0]  cur_status;

    // ------------------------------------------------------------------
    // Decoder
    // ------------------------------------------------------------------

    // Result carrying the header fields of the current frame.
    function automatic wsd_result_t frame_result(input logic summary, input logic [7:0] v);
        wsd_result_t r;
        logic        is_close;
        is_close           = (cur_opcode == OPCODE_CLOSE);
        r.result_kind      = summary;
        r.payload_byte     = summary ? 8'h00 : v;
        r.final_fragment   = cur_fin;
        r.frame_opcode     = cur_opcode;
        r.was_masked       = cur_masked;
        r.frame_length     = cur_length;
        r.close_status     = (summary && is_close) ? cur_status : 16'h0000;
        // status only counts when the close frame had at least one payload byte
        r.status_present   = summary && is_close && (cur_length != 64'd0);
        r.frame_done       = summary;
        return r;
    endfunction

    // Header finished: an empty frame is summarized right away.
    task automatic header_complete();
        if (cur_length == 64'd0) begin
            decoded_queue.push_back(frame_result(1'b1, 8'h00));
            dec_phase = EXP_HEADER;
        end
        else begin
            pay_pos   = 64'd0;
            dec_phase = EXP_PAYLOAD;
        end
    endtask

    task automatic length_complete();
        if (cur_masked) begin
            hdr_left  = 4'd4;
            cur_key   = 32'h0;
            dec_phase = EXP_MASK_KEY;
        end
        else begin
            header_complete();
        end
    endtask

    task automatic decode_byte(input logic [7:0] b);
        logic [7:0] v;
        int         sh;
        case (dec_phase)
            EXP_LENGTH:
            begin
                cur_masked = b[7];
                cur_length = 64'd0;
                if (b[6:0] == LEN_EXT16) begin
                    hdr_left  = 4'd2;
                    dec_phase = EXP_EXT_LEN;
                end
                else if (b[6:0] == LEN_EXT64) begin
                    hdr_left  = 4'd8;
                    dec_phase = EXP_EXT_LEN;
                end
                else begin
                    cur_length = {57'd0, b[6:0]};
                    length_complete();
                end
            end
            EXP_EXT_LEN:
            begin
                cur_length = {cur_length[55:0], b};
                hdr_left   = hdr_left - 4'd1;
                if (hdr_left == 4'd0)
                    length_complete();
            end
            EXP_MASK_KEY:
            begin
                cur_key  = {cur_key[23:0], b};
                hdr_left = hdr_left - 4'd1;
                if (hdr_left == 4'd0)
                    header_complete();
            end
            EXP_PAYLOAD:
            begin
                v = b;
                if (cur_masked) begin
                    // key byte 0 is the first one received
                    sh = 8 * (3 - int'(pay_pos[1:0]));
                    v  = v ^ cur_key[sh +: 8];
                end
                // first two bytes of a close frame are the status, not payload
                if (cur_opcode == OPCODE_CLOSE && pay_pos < 64'd2) begin
                    if (pay_pos == 64'd0)
                        cur_status = {v, 8'h00};
                    else
                        cur_status = cur_status | {8'h00, v};
                end
                else begin
                    decoded_queue.push_back(frame_result(1'b0, v));
                end
                pay_pos = pay_pos + 64'd1;
                if (pay_pos == cur_length) begin
                    decoded_queue.push_back(frame_result(1'b1, 8'h00));
                    dec_phase = EXP_HEADER;
                end
            end
            default:
            begin
                cur_fin    = b[7];
                cur_opcode = b[3:0];
                cur_masked = 1'b0;
                cur_length = 64'd0;
                cur_key    = 32'h0;
                pay_pos    = 64'd0;
                cur_status = 16'h0000;
                hdr_left   = 4'd0;
                dec_phase  = EXP_LENGTH;
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, got_v);
            error_count++;
        end
    endtask

    task automatic check_result();
        wsd_result_t exp_r;
        if (decoded_queue.size() == 0) begin
            $error("result_kind: expected no result, got %0h", result_kind);
            error_count++;
        end
        else begin
            exp_r = decoded_queue.pop_front();
            check_field("result_kind",    64'(exp_r.result_kind),    64'(result_kind));
            check_field("payload_byte",   64'(exp_r.payload_byte),   64'(payload_byte));
            check_field("final_fragment", 64'(exp_r.final_fragment), 64'(final_fragment));
            check_field("frame_opcode",   64'(exp_r.frame_opcode),   64'(frame_opcode));
            check_field("was_masked",     64'(exp_r.was_masked),     64'(was_masked));
            check_field("frame_length",   exp_r.frame_length,        frame_length);
            check_field("close_status",   64'(exp_r.close_status),   64'(close_status));
            check_field("status_present", 64'(exp_r.status_present), 64'(status_present));
            check_field("frame_done",     64'(exp_r.frame_done),     64'(frame_done));
        end
    endtask

    // Scoreboard: every read here sees pre-edge values, so input and output
    // transfers are judged on the same footing as the DUT registers them.
    // Also drives the receiver stall and runs the watchdog.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall)
                decode_byte(data_byte);
            if (out_valid && !out_stall)
                check_result();
            out_stall <= ($urandom_range(99) < stall_pct);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("** websocket_frame_deframer: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // One byte transfer, after a random number of idle cycles.
    // Returns at the edge where the transfer happened.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        bytes_sent++;
    endtask

    // Whole frame: header, length in the requested form, optional random key,
    // then n_payload random bytes.
    task automatic send_frame(input logic [7:0] first_byte, input logic masked,
                              input logic [63:0] len, input len_form_t form,
                              input int n_payload);
        int i;
        send_byte(first_byte);
        case (form)
            FORM_EXT16:
            begin
                send_byte({masked, LEN_EXT16});
                for (i = 1; i >= 0; i--)
                    send_byte(len[8*i +: 8]);
            end
            FORM_EXT64:
            begin
                send_byte({masked, LEN_EXT64});
                for (i = 7; i >= 0; i--)
                    send_byte(len[8*i +: 8]);
            end
            default:
                send_byte({masked, len[6:0]});
        endcase
        if (masked)
            repeat (4) send_byte(8'($urandom_range(255)));
        repeat (n_payload) send_byte(8'($urandom_range(255)));
    endtask

    // Zero-length frames: summary on the last header byte, masked or not.
    task automatic test_empty_frames();
        send_idle_pct = 0;
        stall_pct     = 0;
        send_frame({4'h8, OP_PING}, 1'b0, 64'd0, FORM_SHORT, 0);
        // empty close: no status, status_present low
        send_frame({4'h8, OPCODE_CLOSE}, 1'b1, 64'd0, FORM_SHORT, 0);
    endtask

    // Close status handling: one byte gives byte<<8, three bytes give a
    // status plus one emitted payload byte right before the summary.
    task automatic test_close_status();
        send_frame({4'h8, OPCODE_CLOSE}, 1'b0, 64'd1, FORM_SHORT, 1);
        send_frame({4'h0, OPCODE_CLOSE}, 1'b1, 64'd3, FORM_SHORT, 3);
    endtask

    // 16-bit extended length carrying a value that fits in seven bits.
    task automatic test_extended_length();
        send_frame({4'h8, OP_BINARY}, 1'b0, 64'd1, FORM_EXT16, 1);
    endtask

    // Back-to-back random frames under one idle/stall profile.
    task automatic test_random_frames(input int idle_pct, input int stall_p,
                                      input int n_bytes);
        int          start;
        int          pick;
        logic [3:0]  opc;
        logic [63:0] len;
        len_form_t   form;
        send_idle_pct = idle_pct;
        stall_pct     = stall_p;
        start         = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            pick = $urandom_range(9);
            case (pick)
                0, 1:    opc = OPCODE_CLOSE;
                2:       opc = 4'($urandom_range(15));
                3:       opc = OP_CONT;
                4, 5:    opc = OP_TEXT;
                6, 7:    opc = OP_BINARY;
                8:       opc = OP_PING;
                default: opc = OP_PONG;
            endcase
            if (opc == OPCODE_CLOSE) begin
                // short close frames exercise the status corner cases
                len = 64'($urandom_range(4));
            end
            else begin
                pick = $urandom_range(19);
                if (pick < 11)
                    len = 64'($urandom_range(6));
                else if (pick < 18)
                    len = 64'($urandom_range(40, 7));
                else if (pick == 18)
                    len = 64'($urandom_range(125, 41));
                else
                    len = 64'($urandom_range(200, 126));
            end
            if (len > 64'd125) begin
                form = ($urandom_range(1) != 0) ? FORM_EXT16 : FORM_EXT64;
            end
            else begin
                pick = $urandom_range(9);
                if (pick < 7)
                    form = FORM_SHORT;
                else if (pick < 9)
                    form = FORM_EXT16;
                else
                    form = FORM_EXT64;
            end
            // random FIN and reserved bits
            send_frame({1'($urandom_range(1)), 3'($urandom_range(7)), opc},
                       1'($urandom_range(1)), len, form, int'(len));
        end
    endtask

    // 64-bit length with the top bit set: taken as is. The frame never ends,
    // so this runs last and only a few payload bytes are sent.
    task automatic test_huge_length();
        logic [63:0] len;
        send_idle_pct = 22;
        stall_pct     = 22;
        len           = {$urandom, $urandom};
        len[63]       = 1'b1;
        send_frame({4'h8, OP_BINARY}, 1'b1, len, FORM_EXT64, 6);
    endtask

    initial begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        data_byte     = 8'h00;
        out_stall     = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        bytes_sent    = 0;
        error_count   = 0;
        quiet_cycles  = 0;
        dec_phase     = EXP_HEADER;
        hdr_left      = 4'd0;
        cur_fin       = 1'b0;
        cur_opcode    = 4'h0;
        cur_masked    = 1'b0;
        cur_length    = 64'd0;
        cur_key       = 32'h0;
        pay_pos       = 64'd0;
        cur_status    = 16'h0000;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_frames();
        test_close_status();
        test_extended_length();
        // no idling, idle sender, stalling receiver, both
        test_random_frames(0, 0, 125);
        test_random_frames(82, 0, 125);
        test_random_frames(0, 82, 125);
        test_random_frames(22, 22, 125);
        test_huge_length();

        in_valid <= 1'b0;
        stall_pct = 0;
        while (decoded_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);

        if (error_count == 0)
            $display("** websocket_frame_deframer: PASSED **");
        else
            $display("** websocket_frame_deframer: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
